### sv/tfb_pkg.sv
// Package for the telemetry frame builder.
// Holds the item and command types, the framing constants and the sequencer phases.
// No dependencies.
package tfb_pkg;

  localparam int unsigned WordBytes = 4;
  localparam int unsigned WordW     = WordBytes * 8;
  localparam int unsigned ByteCntW  = (WordBytes > 1) ? $clog2(WordBytes) : 1;
  localparam int unsigned CmdDepth  = 2;
  localparam int unsigned CmdPtrW   = (CmdDepth > 1) ? $clog2(CmdDepth) : 1;

  localparam logic [7:0] SyncByte      = 8'hAA;
  localparam logic [7:0] FuncCodeReset = 8'hF1;

  typedef struct packed {
    logic [31:0] value_bits;
    logic [5:0]  frame_words;
    logic        start_of_frame;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       end_of_frame;
    logic       last_of_run;
  } out_item_t;

  // What one accepted word asks the serialiser to send.
  typedef struct packed {
    logic        hdr;
    logic [7:0]  len_byte;
    logic        word_vld;
    logic [31:0] word;
    logic        trailer;
  } cmd_t;

  typedef enum logic [2:0] {
    PhStart,
    PhSync0,
    PhSync1,
    PhFunc,
    PhLen,
    PhWord,
    PhTrl
  } phase_e;

endpackage

### sv/tfb_front.sv
// Front end of the telemetry frame builder: tracks the open frame and turns each
// accepted word into a serialiser command.
// Depends on tfb_pkg.
module tfb_front (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             accept_i,
  input  tfb_pkg::in_item_t item_i,
  output tfb_pkg::cmd_t    cmd_o,
  output logic             cmd_vld_o
);

  logic [5:0] words_left_q, words_left_d;
  logic       frame_open_q, frame_open_d;
  tfb_pkg::cmd_t cmd;

  always_comb begin
    cmd          = '0;
    words_left_d = words_left_q;
    frame_open_d = frame_open_q;
    if (item_i.start_of_frame) begin
      // A new start abandons any unfinished frame without a trailer.
      cmd.hdr      = 1'b1;
      cmd.len_byte = 8'(32'(item_i.frame_words) * tfb_pkg::WordBytes);
      frame_open_d = 1'b1;
      words_left_d = item_i.frame_words;
      if (item_i.frame_words == 6'd0) begin
        cmd.trailer  = 1'b1;
        frame_open_d = 1'b0;
      end
    end
    if (frame_open_d && (words_left_d != 6'd0)) begin
      cmd.word_vld = 1'b1;
      cmd.word     = item_i.value_bits;
      words_left_d = words_left_d - 6'd1;
      if (words_left_d == 6'd0) begin
        cmd.trailer  = 1'b1;
        frame_open_d = 1'b0;
      end
    end
  end

  assign cmd_o     = cmd;
  assign cmd_vld_o = cmd.hdr | cmd.word_vld;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      words_left_q <= '0;
      frame_open_q <= 1'b0;
    end else if (accept_i) begin
      words_left_q <= words_left_d;
      frame_open_q <= frame_open_d;
    end
  end

endmodule

### sv/tfb_cmd_queue.sv
// Short command queue between the front end and the serialiser.
// The head entry stays visible until the serialiser has finished with it.
// Depends on tfb_pkg.
module tfb_cmd_queue (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  tfb_pkg::cmd_t wdata_i,
  output logic          full_o,
  input  logic          pop_i,
  output tfb_pkg::cmd_t head_o,
  output logic          head_vld_o
);

  tfb_pkg::cmd_t mem_q [tfb_pkg::CmdDepth];
  logic [tfb_pkg::CmdPtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [tfb_pkg::CmdPtrW:0]   count_q, count_d;
  logic do_push, do_pop;

  assign full_o     = (count_q == (tfb_pkg::CmdPtrW + 1)'(tfb_pkg::CmdDepth));
  assign head_vld_o = (count_q != '0);
  assign head_o     = mem_q[rd_ptr_q];
  assign do_push    = push_i && !full_o;
  assign do_pop     = pop_i && head_vld_o;

  always_comb begin
    count_d = count_q;
    if (do_push && !do_pop) begin
      count_d = count_q + 1'b1;
    end else if (!do_push && do_pop) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      count_q <= count_d;
      if (do_push) begin
        wr_ptr_q <= (wr_ptr_q == tfb_pkg::CmdPtrW'(tfb_pkg::CmdDepth - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == tfb_pkg::CmdPtrW'(tfb_pkg::CmdDepth - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
    end
  end

endmodule

### sv/tfb_back.sv
// Back end of the telemetry frame builder: serialises the head command into bytes,
// keeps the frame checksum and drives the result register.
// Depends on tfb_pkg.
module tfb_back (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  tfb_pkg::cmd_t      head_i,
  input  logic               head_vld_i,
  output logic               head_pop_o,
  input  logic [7:0]         func_code_i,
  input  logic               pop_i,
  output logic               empty_o,
  output tfb_pkg::out_item_t out_item_o
);

  tfb_pkg::phase_e phase_q, phase_d, eff_phase;
  logic [tfb_pkg::ByteCntW-1:0] cnt_q, cnt_d;
  logic [tfb_pkg::WordW-1:0]    shift_q, shift_d, word_src;
  logic [7:0] sum_q, sum_d;
  logic [7:0] byte_val;
  logic       is_trailer, clr_sum, is_last, cnt_last, fire;
  logic       out_vld_q;
  tfb_pkg::out_item_t out_q;

  assign fire      = head_vld_i && (!out_vld_q || pop_i);
  assign eff_phase = (phase_q == tfb_pkg::PhStart) ?
                     (head_i.hdr ? tfb_pkg::PhSync0 : tfb_pkg::PhWord) : phase_q;
  assign word_src  = (cnt_q == '0) ? tfb_pkg::WordW'(head_i.word) : shift_q;
  assign cnt_last  = (cnt_q == tfb_pkg::ByteCntW'(tfb_pkg::WordBytes - 1));

  // Byte selection for the current phase.
  always_comb begin
    byte_val   = tfb_pkg::SyncByte;
    is_trailer = 1'b0;
    clr_sum    = 1'b0;
    case (eff_phase)
      tfb_pkg::PhSync0: begin
        clr_sum = 1'b1;
      end
      tfb_pkg::PhSync1: begin
        byte_val = tfb_pkg::SyncByte;
      end
      tfb_pkg::PhFunc: begin
        byte_val = func_code_i;
      end
      tfb_pkg::PhLen: begin
        byte_val = head_i.len_byte;
      end
      tfb_pkg::PhWord: begin
        byte_val = word_src[tfb_pkg::WordW-1 -: 8];
      end
      tfb_pkg::PhTrl: begin
        byte_val   = sum_q;
        is_trailer = 1'b1;
      end
      default: begin
        byte_val = tfb_pkg::SyncByte;
      end
    endcase
  end

  // Phase sequencing; returning to the start phase marks the command's final byte.
  always_comb begin
    phase_d = phase_q;
    cnt_d   = cnt_q;
    case (eff_phase)
      tfb_pkg::PhSync0: phase_d = tfb_pkg::PhSync1;
      tfb_pkg::PhSync1: phase_d = tfb_pkg::PhFunc;
      tfb_pkg::PhFunc:  phase_d = tfb_pkg::PhLen;
      tfb_pkg::PhLen: begin
        if (head_i.word_vld) begin
          phase_d = tfb_pkg::PhWord;
        end else if (head_i.trailer) begin
          phase_d = tfb_pkg::PhTrl;
        end else begin
          phase_d = tfb_pkg::PhStart;
        end
      end
      tfb_pkg::PhWord: begin
        if (cnt_last) begin
          cnt_d   = '0;
          phase_d = head_i.trailer ? tfb_pkg::PhTrl : tfb_pkg::PhStart;
        end else begin
          cnt_d   = cnt_q + 1'b1;
          phase_d = tfb_pkg::PhWord;
        end
      end
      tfb_pkg::PhTrl:   phase_d = tfb_pkg::PhStart;
      default:          phase_d = tfb_pkg::PhStart;
    endcase
  end

  assign is_last    = (phase_d == tfb_pkg::PhStart);
  assign head_pop_o = fire && is_last;
  assign shift_d    = word_src << 8;
  assign sum_d      = is_trailer ? 8'h00 : ((clr_sum ? 8'h00 : sum_q) + byte_val);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= tfb_pkg::PhStart;
      cnt_q     <= '0;
      sum_q     <= '0;
      out_vld_q <= 1'b0;
    end else begin
      if (fire) begin
        phase_q <= phase_d;
        cnt_q   <= cnt_d;
        sum_q   <= sum_d;
      end
      out_vld_q <= fire || (out_vld_q && !pop_i);
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      shift_q <= shift_d;
      out_q   <= '{out_byte: byte_val, end_of_frame: is_trailer, last_of_run: is_last};
    end
  end

  assign empty_o    = !out_vld_q;
  assign out_item_o = out_q;

endmodule

### sv/telemetry_frame_builder.sv
// Top level of the telemetry frame builder: function code register, front end,
// command queue and byte serialiser.
// Depends on tfb_pkg, tfb_front, tfb_cmd_queue and tfb_back.
//
//   Channel   Handshake            Payload
//   input     push_i / full_o      in_item_i   (sample word, word count, start flag)
//   result    pop_i / empty_o      out_item_o  (frame byte, trailer flag, last flag)
//   config    cfg_we_i             cfg_wdata_i (function code)
//
// Bytes leave at one per cycle while a command is queued and the result register is
// empty or popped: a word gives WordBytes (4) bytes, a frame start adds four header
// bytes and the trailer adds one, so an item's 0 to 9 bytes set the sustained rate.
// A two-entry command queue lets the front end take new words while the
// serialiser works, and the result register holds a byte while pop_i is low.
// rst_ni clears all frame state asynchronously; the function code resets to 0xF1.
module telemetry_frame_builder (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push_i,
  output logic               full_o,
  input  tfb_pkg::in_item_t  in_item_i,
  input  logic               pop_i,
  output logic               empty_o,
  output tfb_pkg::out_item_t out_item_o,
  input  logic               cfg_we_i,
  input  logic [7:0]         cfg_wdata_i
);

  logic [7:0]    func_code_q;
  logic          accept, cmd_vld, cmd_push, q_full, head_vld, head_pop;
  tfb_pkg::cmd_t cmd, head;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      func_code_q <= tfb_pkg::FuncCodeReset;
    end else if (cfg_we_i) begin
      func_code_q <= cfg_wdata_i;
    end
  end

  assign full_o   = q_full;
  assign accept   = push_i && !q_full;
  assign cmd_push = accept && cmd_vld;

  tfb_front u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .accept_i  (accept),
    .item_i    (in_item_i),
    .cmd_o     (cmd),
    .cmd_vld_o (cmd_vld)
  );

  tfb_cmd_queue u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (cmd_push),
    .wdata_i    (cmd),
    .full_o     (q_full),
    .pop_i      (head_pop),
    .head_o     (head),
    .head_vld_o (head_vld)
  );

  tfb_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .head_i      (head),
    .head_vld_i  (head_vld),
    .head_pop_o  (head_pop),
    .func_code_i (func_code_q),
    .pop_i       (pop_i),
    .empty_o     (empty_o),
    .out_item_o  (out_item_o)
  );

`ifndef SYNTH
  // The trailer always closes the run of bytes for its command.
  a_trailer_is_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty_o && out_item_o.end_of_frame) |-> out_item_o.last_of_run)
    else $error("trailer byte without last_of_run");

  // The serialiser only releases a command that is actually queued.
  a_pop_has_head: assert property (@(posedge clk_i) disable iff (!rst_ni)
    head_pop |-> head_vld)
    else $error("command released from an empty queue");

  // A released result byte is replaced only by serialiser work.
  a_empty_after_pop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pop_i && !empty_o && !head_vld) |=> empty_o)
    else $error("result appeared without a queued command");
`endif

endmodule
